>>> hw/rtl/mtws_pkg.sv
// types and constants shared by the multi-task watchdog supervisor
package mtws_pkg;

  localparam int MAX_TASKS = 4;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 3;

  // item kinds
  localparam logic [2:0] KIND_INIT   = 3'd0;
  localparam logic [2:0] KIND_TICK   = 3'd1;
  localparam logic [2:0] KIND_CHECK  = 3'd2;
  localparam logic [2:0] KIND_REPORT = 3'd3;
  localparam logic [2:0] KIND_ENABLE = 3'd4;
  localparam logic [2:0] KIND_START  = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_INIT = 2'd1;
  localparam logic [1:0] ST_BAD_TASK = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_PERIOD = 3'd5;

  localparam logic [TIME_W-1:0]    TIMEOUT_RST     = 32'd100;
  localparam logic [MAX_TASKS-1:0] ENABLE_MASK_RST = 4'hf;
  localparam logic [TIME_W-1:0]    KICK_PERIOD_RST = 32'd10;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] task_index;
    logic       enable_value;
  } in_item_t;

  typedef struct packed {
    logic                 kick;
    logic [1:0]           status;
    logic                 all_ok;
    logic                 running;
    logic [MAX_TASKS-1:0] enable_mask;
    logic                 late_flag;
    logic [1:0]           late_task;
  } out_item_t;

endpackage

>>> hw/rtl/multi_task_watchdog_supervisor_top.sv
// multi-task watchdog supervisor: task timeout checks and watchdog kick decision
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid / in_ready    | in_data (in_item_t)
//   out     | output    | out_valid / out_ready  | out_data (out_item_t)
//   cfg     | input     | cfg_wr_en, no wait     | cfg_index, cfg_data
//
// every item updates state and the result register at the accept edge, and the result
// shows the cycle after; one item per cycle is sustained through the single output
// register while out_ready keeps it drained, with the per-task elapsed-time compares in parallel.
// rst is synchronous; it clears all state and loads the register defaults.
// a stalled result holds in the output register and the input stalls only while it is full
// and not taken.
module multi_task_watchdog_supervisor_top #(
  parameter int NUM_TASKS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mtws_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mtws_pkg::out_item_t               out_data,
  input  logic                              cfg_wr_en,
  input  logic [mtws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mtws_pkg::TIME_W-1:0]       cfg_data
);
  import mtws_pkg::*;

  // configuration
  logic [TIME_W-1:0]    timeout [MAX_TASKS];
  logic [MAX_TASKS-1:0] init_mask;
  logic [TIME_W-1:0]    kick_period;

  // supervisor state
  logic [TIME_W-1:0] now_time, now_time_next;
  logic [TIME_W-1:0] report_time [NUM_TASKS];
  logic [TIME_W-1:0] report_time_next [NUM_TASKS];
  logic [NUM_TASKS-1:0] task_enable, task_enable_next;
  logic [TIME_W-1:0] last_kick_time, last_kick_time_next;
  logic ok_flag, ok_flag_next;
  logic started, started_next;
  logic initialized, initialized_next;

  logic                 accept;
  logic [NUM_TASKS-1:0] late_vec;
  logic                 kick_due;
  logic                 idx_ok;
  logic                 any_late;
  logic [1:0]           late_idx;
  out_item_t            result;
  logic [TIME_W-1:0]    elapsed [NUM_TASKS];
  logic [TIME_W-1:0]    kick_elapsed;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        timeout[i] <= TIMEOUT_RST;
      end
      init_mask   <= ENABLE_MASK_RST;
      kick_period <= KICK_PERIOD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TIMEOUT0:    timeout[0] <= cfg_data;
        REG_TIMEOUT1:    timeout[1] <= cfg_data;
        REG_TIMEOUT2:    timeout[2] <= cfg_data;
        REG_TIMEOUT3:    timeout[3] <= cfg_data;
        REG_ENABLE_MASK: init_mask <= cfg_data[MAX_TASKS-1:0];
        REG_KICK_PERIOD: kick_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-task wrapping elapsed time, all in parallel
  always_comb begin
    for (int i = 0; i < NUM_TASKS; i++) begin
      elapsed[i]  = now_time - report_time[i];
      late_vec[i] = task_enable[i] && (elapsed[i] > timeout[i]);
    end
  end

  // lowest late task wins
  always_comb begin
    any_late = |late_vec;
    late_idx = '0;
    for (int i = NUM_TASKS - 1; i >= 0; i--) begin
      if (late_vec[i]) begin
        late_idx = 2'(i);
      end
    end
  end

  assign kick_elapsed = now_time - last_kick_time;
  assign kick_due     = kick_elapsed >= kick_period;
  assign idx_ok       = in_data.task_index < 3'(NUM_TASKS);

  always_comb begin
    now_time_next       = now_time;
    report_time_next    = report_time;
    task_enable_next    = task_enable;
    last_kick_time_next = last_kick_time;
    ok_flag_next        = ok_flag;
    started_next        = started;
    initialized_next    = initialized;
    result              = '0;
    result.status       = ST_OK;

    if (in_data.kind == KIND_TICK) begin
      now_time_next = now_time + 1'b1;
    end else if (in_data.kind == KIND_INIT) begin
      if (!initialized) begin
        initialized_next = 1'b1;
        started_next     = 1'b0;
        for (int i = 0; i < NUM_TASKS; i++) begin
          task_enable_next[i] = init_mask[i];
          report_time_next[i] = now_time;
        end
      end
    end else if (!initialized) begin
      result.status = ST_NOT_INIT;
    end else begin
      case (in_data.kind)
        KIND_CHECK: begin
          if (started) begin
            if (any_late) begin
              ok_flag_next     = 1'b0;
              result.late_flag = 1'b1;
              result.late_task = late_idx;
            end else if (ok_flag) begin
              // zero period kicks on every passing check without moving the mark
              if (kick_period == '0) begin
                result.kick = 1'b1;
              end else if (kick_due) begin
                result.kick         = 1'b1;
                last_kick_time_next = now_time;
              end
            end
          end
        end
        KIND_REPORT, KIND_ENABLE: begin
          if (!idx_ok) begin
            result.status = ST_BAD_TASK;
          end else begin
            for (int i = 0; i < NUM_TASKS; i++) begin
              if (3'(i) == in_data.task_index) begin
                if (in_data.kind == KIND_REPORT) begin
                  report_time_next[i] = now_time;
                end else if (in_data.enable_value != task_enable[i]) begin
                  report_time_next[i] = now_time;
                  task_enable_next[i] = in_data.enable_value;
                end
              end
            end
          end
        end
        KIND_START: begin
          last_kick_time_next = now_time;
          ok_flag_next        = 1'b1;
          started_next        = 1'b1;
          for (int i = 0; i < NUM_TASKS; i++) begin
            report_time_next[i] = now_time;
          end
        end
        default: ;
      endcase
    end

    result.all_ok      = ok_flag_next;
    result.running     = started_next;
    result.enable_mask = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      result.enable_mask[i] = task_enable_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_time       <= '0;
      task_enable    <= '0;
      last_kick_time <= '0;
      ok_flag        <= 1'b0;
      started        <= 1'b0;
      initialized    <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        report_time[i] <= '0;
      end
    end else if (accept) begin
      now_time       <= now_time_next;
      task_enable    <= task_enable_next;
      last_kick_time <= last_kick_time_next;
      ok_flag        <= ok_flag_next;
      started        <= started_next;
      initialized    <= initialized_next;
      report_time    <= report_time_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  // a late check never leaves the flag set
  a_late_clears_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.late_flag |-> !out_data.all_ok)
    else $error("late check reported with all_ok set");

  // a kick only comes from a running supervisor with all tasks healthy
  a_kick_needs_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kick |-> out_data.all_ok && out_data.running)
    else $error("kick without running and all_ok");

  // before init nothing is enabled or running
  a_not_init_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_NOT_INIT |->
      out_data.enable_mask == '0 && !out_data.running)
    else $error("not-initialized result shows live state");

  // an empty output register never stalls the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // reset leaves no result behind
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule
